FILE: design/nsfp_pkg.sv
// Shared types, character codes and field tables of the NMEA sentence field parser.
// Depends on nothing; every other design file but nsfp_if imports it.
package nsfp_pkg;

	// Longest line the parser can track, and the width of the line byte counter.
	localparam int MAX_LINE = 128;
	localparam int CNT_W = $clog2(MAX_LINE + 1);
	localparam logic [7:0] LIMIT_RESET = 8'd82;

	// Field values and the saturation ceiling.
	localparam int VAL_W = 31;
	localparam int SPEED_W = 42;
	localparam int NUM_SLOTS = 9;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;
	localparam logic [SPEED_W-1:0] SPEED_SCALE = 42'd1852;

	// Characters of interest.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_W = 8'h57;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// Sentence kinds.
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_GGA = 3'd1;
	localparam logic [2:0] KIND_RMC = 3'd2;
	localparam logic [2:0] KIND_GLL = 3'd3;
	localparam logic [2:0] KIND_GNS = 3'd4;

	// Destination codes of a field: a value slot, a hemisphere mark, or nothing.
	localparam logic [3:0] SLOT_TIME = 4'd0;
	localparam logic [3:0] SLOT_LAT = 4'd1;
	localparam logic [3:0] SLOT_LON = 4'd2;
	localparam logic [3:0] SLOT_SATS = 4'd3;
	localparam logic [3:0] SLOT_HDOP = 4'd4;
	localparam logic [3:0] SLOT_ALT = 4'd5;
	localparam logic [3:0] SLOT_AGE = 4'd6;
	localparam logic [3:0] SLOT_SPEED = 4'd7;
	localparam logic [3:0] SLOT_DATE = 4'd8;
	localparam logic [3:0] MAP_NS = 4'd9;
	localparam logic [3:0] MAP_EW = 4'd10;
	localparam logic [3:0] MAP_NONE = 4'd15;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [7:0] char_t;

	// What the line parser hands to the fix store for one accepted byte.
	typedef struct packed {
		logic fire;
		logic [1:0] status;
		logic [2:0] kind;
		logic commit;
		logic [NUM_SLOTS-1:0] pvalid;
		val_t [NUM_SLOTS-1:0] pval;
		char_t [1:0] phemi;
	} ev_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] sentence_kind;
		logic [30:0] fix_time;
		logic signed [31:0] latitude;
		logic signed [31:0] longitude;
		logic [30:0] satellites;
		logic [30:0] hdop;
		logic [30:0] altitude;
		logic [30:0] fix_age;
		logic [41:0] speed_scaled;
		logic [30:0] fix_date;
	} fix_t;

	// Where field number idx of a sentence of the given kind goes.
	function automatic logic [3:0] map_code(input logic [2:0] kind, input logic [7:0] idx);
		logic [3:0] code;
		code = MAP_NONE;
		case (kind)
			KIND_GGA, KIND_GNS: begin
				case (idx)
					8'd0: code = SLOT_TIME;
					8'd1: code = SLOT_LAT;
					8'd2: code = MAP_NS;
					8'd3: code = SLOT_LON;
					8'd4: code = MAP_EW;
					8'd6: code = SLOT_SATS;
					8'd7: code = SLOT_HDOP;
					8'd8: code = SLOT_ALT;
					8'd10: code = (kind == KIND_GNS) ? SLOT_AGE : MAP_NONE;
					8'd12: code = (kind == KIND_GGA) ? SLOT_AGE : MAP_NONE;
					default: code = MAP_NONE;
				endcase
			end
			KIND_RMC: begin
				case (idx)
					8'd0: code = SLOT_TIME;
					8'd2: code = SLOT_LAT;
					8'd3: code = MAP_NS;
					8'd4: code = SLOT_LON;
					8'd5: code = MAP_EW;
					8'd6: code = SLOT_SPEED;
					8'd8: code = SLOT_DATE;
					default: code = MAP_NONE;
				endcase
			end
			KIND_GLL: begin
				case (idx)
					8'd0: code = SLOT_LAT;
					8'd1: code = MAP_NS;
					8'd2: code = SLOT_LON;
					8'd3: code = MAP_EW;
					8'd4: code = SLOT_TIME;
					default: code = MAP_NONE;
				endcase
			end
			default: code = MAP_NONE;
		endcase
		return code;
	endfunction

endpackage

FILE: design/nsfp_if.sv
// Channel interfaces of the NMEA sentence field parser: bytes in, results out, config.
// Depends on no other file; the payload fields are plain logic vectors.
interface nsfp_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsfp_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] line_limit;
	modport source (output valid, output line_limit, input ready);
	modport sink (input valid, input line_limit, output ready);
endinterface

interface nsfp_fix_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [2:0] sentence_kind;
	logic [30:0] fix_time;
	logic signed [31:0] latitude;
	logic signed [31:0] longitude;
	logic [30:0] satellites;
	logic [30:0] hdop;
	logic [30:0] altitude;
	logic [30:0] fix_age;
	logic [41:0] speed_scaled;
	logic [30:0] fix_date;
	modport source (output valid, output status, output sentence_kind, output fix_time,
		output latitude, output longitude, output satellites, output hdop,
		output altitude, output fix_age, output speed_scaled, output fix_date,
		input ready);
	modport sink (input valid, input status, input sentence_kind, input fix_time,
		input latitude, input longitude, input satellites, input hdop,
		input altitude, input fix_age, input speed_scaled, input fix_date,
		output ready);
endinterface

FILE: design/nsfp_line_parser.sv
// Input register and per-byte line state: mnemonic, field accumulation, pending values.
// Depends on nsfp_pkg; feeds nsfp_fix_store through an ev_t event.
module nsfp_line_parser
	import nsfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] in_byte,
	output logic in_ready,
	input logic [7:0] line_limit,
	input logic slot_free,
	output ev_t ev
);

	typedef struct packed {
		logic in_line;
		logic [CNT_W-1:0] cnt;
		char_t [2:0] mnem;
		logic [7:0] comma;
		val_t accum;
		logic bad;
		char_t first;
		val_t [NUM_SLOTS-1:0] pval;
		logic [NUM_SLOTS-1:0] pvalid;
		char_t [1:0] phemi;
	} pst_t;

	pst_t st_q, st_d;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic adv;
	logic ovf;
	logic [CNT_W-1:0] limit;
	char_t [2:0] mnem_n;
	logic [2:0] kind_n;
	logic [3:0] code;
	logic [7:0] fidx;
	val_t fval;
	logic [VAL_W+3:0] acc_n;

	// A byte moves on when the result slot can take whatever it causes.
	assign adv = valid_s1 && slot_free;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	// Effective line limit is the smaller of the register and MAX_LINE.
	assign limit = (int'(line_limit) < MAX_LINE) ? CNT_W'(line_limit) : CNT_W'(MAX_LINE);
	assign ovf = st_q.in_line && (st_q.cnt >= limit);
	assign fidx = st_q.comma - 8'd1;
	assign fval = st_q.bad ? '0 : st_q.accum;
	assign acc_n = ({4'b0, st_q.accum} << 3) + ({4'b0, st_q.accum} << 1)
		+ (VAL_W+4)'(byte_s1 - CH_ZERO);

	// Mnemonic bytes including one written by this byte.
	always_comb begin
		mnem_n = st_q.mnem;
		if (st_q.cnt >= CNT_W'(3) && st_q.cnt <= CNT_W'(5)) begin
			mnem_n[2'(st_q.cnt - CNT_W'(3))] = byte_s1;
		end
	end

	// Sentence kind from the mnemonic bytes.
	always_comb begin
		kind_n = KIND_NONE;
		if (mnem_n[0] == CH_G && mnem_n[1] == CH_G && mnem_n[2] == CH_A) begin
			kind_n = KIND_GGA;
		end else if (mnem_n[0] == CH_R && mnem_n[1] == CH_M
			&& mnem_n[2] == CH_C) begin
			kind_n = KIND_RMC;
		end else if (mnem_n[0] == CH_G && mnem_n[1] == CH_L
			&& mnem_n[2] == CH_L) begin
			kind_n = KIND_GLL;
		end else if (mnem_n[0] == CH_G && mnem_n[1] == CH_N
			&& mnem_n[2] == CH_S) begin
			kind_n = KIND_GNS;
		end
	end

	assign code = map_code(kind_n, fidx);

	// Next line state and the event for the fix store.
	always_comb begin
		st_d = st_q;
		ev = '0;
		if (adv) begin
			if (ovf) begin
				st_d.in_line = 1'b0;
				ev.fire = 1'b1;
				ev.status = ST_OVERFLOW;
			end
			if (!st_d.in_line || byte_s1 == CH_DOLLAR) begin
				if (byte_s1 == CH_DOLLAR) begin
					st_d = '0;
					st_d.in_line = 1'b1;
					st_d.cnt = CNT_W'(1);
				end
			end else if (byte_s1 != CH_CR) begin
				st_d.mnem = mnem_n;
				st_d.cnt = st_q.cnt + CNT_W'(1);
				if (byte_s1 == CH_LF || byte_s1 == CH_COMMA) begin
					// Hemisphere mark from the first byte of the closing field.
					if (st_q.comma != 8'd0) begin
						if (code == MAP_NS && (st_q.first == CH_N || st_q.first == CH_S)) begin
							st_d.phemi[0] = st_q.first;
						end
						if (code == MAP_EW && (st_q.first == CH_E || st_q.first == CH_W)) begin
							st_d.phemi[1] = st_q.first;
						end
					end
				end
				if (byte_s1 == CH_LF) begin
					st_d.in_line = 1'b0;
					ev.fire = 1'b1;
					ev.status = (kind_n != KIND_NONE) ? ST_OK : ST_UNKNOWN;
					ev.kind = kind_n;
					ev.commit = (kind_n != KIND_NONE);
				end else if (byte_s1 == CH_COMMA) begin
					if (st_q.comma != 8'd0 && code <= SLOT_DATE && fval != '0) begin
						st_d.pval[code] = fval;
						st_d.pvalid[code] = 1'b1;
					end
					if (st_q.comma != 8'hFF) begin
						st_d.comma = st_q.comma + 8'd1;
					end
					st_d.accum = '0;
					st_d.bad = 1'b0;
					st_d.first = '0;
				end else begin
					if (st_q.first == 8'd0) begin
						st_d.first = byte_s1;
					end
					if (byte_s1 >= CH_ZERO && byte_s1 <= CH_NINE) begin
						st_d.accum = (acc_n > (VAL_W+4)'(VAL_MAX)) ? VAL_MAX : acc_n[VAL_W-1:0];
					end else if (byte_s1 != CH_DOT) begin
						st_d.bad = 1'b1;
					end
				end
			end
		end
		ev.pval = st_d.pval;
		ev.pvalid = st_d.pvalid;
		ev.phemi = st_d.phemi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= st_d;
		end
	end

endmodule

FILE: design/nsfp_fix_store.sv
// Stored fix values, hemisphere marks, commit logic and the result register.
// Depends on nsfp_pkg; driven by the ev_t event of nsfp_line_parser.
module nsfp_fix_store
	import nsfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input ev_t ev,
	input logic out_ready,
	output logic out_valid,
	output fix_t out_fix,
	output logic slot_free
);

	typedef struct packed {
		val_t ftime;
		logic signed [31:0] lat;
		logic signed [31:0] lon;
		val_t sats;
		val_t hdop;
		val_t alt;
		val_t age;
		logic [SPEED_W-1:0] speed;
		val_t date;
		char_t ns;
		char_t ew;
	} sto_t;

	sto_t sto_q, sto_d;
	logic out_valid_q;
	fix_t out_q;

	// Magnitude signed by a hemisphere mark; no mark keeps the value as stored.
	function automatic logic signed [31:0] signed_by(input logic signed [31:0] v,
		input char_t mark, input char_t pos, input char_t neg);
		logic signed [31:0] a;
		a = v[31] ? -v : v;
		if (mark == pos) begin
			return a;
		end else if (mark == neg) begin
			return -a;
		end
		return v;
	endfunction

	assign slot_free = !out_valid_q || out_ready;

	// Commit of a known sentence.
	always_comb begin
		sto_d = sto_q;
		if (ev.commit) begin
			if (ev.pvalid[SLOT_TIME]) sto_d.ftime = ev.pval[SLOT_TIME];
			if (ev.pvalid[SLOT_LAT]) sto_d.lat = {1'b0, ev.pval[SLOT_LAT]};
			if (ev.pvalid[SLOT_LON]) sto_d.lon = {1'b0, ev.pval[SLOT_LON]};
			if (ev.pvalid[SLOT_SATS]) sto_d.sats = ev.pval[SLOT_SATS];
			if (ev.pvalid[SLOT_HDOP]) sto_d.hdop = ev.pval[SLOT_HDOP];
			if (ev.pvalid[SLOT_ALT]) sto_d.alt = ev.pval[SLOT_ALT];
			if (ev.pvalid[SLOT_AGE]) sto_d.age = ev.pval[SLOT_AGE];
			if (ev.pvalid[SLOT_SPEED]) begin
				sto_d.speed = SPEED_W'(ev.pval[SLOT_SPEED]) * SPEED_SCALE;
			end
			if (ev.pvalid[SLOT_DATE]) sto_d.date = ev.pval[SLOT_DATE];
			if (ev.phemi[0] != 8'd0) sto_d.ns = ev.phemi[0];
			if (ev.phemi[1] != 8'd0) sto_d.ew = ev.phemi[1];
			sto_d.lat = signed_by(sto_d.lat, sto_d.ns, CH_N, CH_S);
			sto_d.lon = signed_by(sto_d.lon, sto_d.ew, CH_E, CH_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sto_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ev.fire) begin
				sto_q <= sto_d;
			end
			out_valid_q <= (out_valid_q && !out_ready) || ev.fire;
		end
	end

	// Result register: the stored values after any commit.
	always_ff @(posedge clk) begin
		if (ev.fire) begin
			out_q.status <= ev.status;
			out_q.sentence_kind <= ev.kind;
			out_q.fix_time <= sto_d.ftime;
			out_q.latitude <= sto_d.lat;
			out_q.longitude <= sto_d.lon;
			out_q.satellites <= sto_d.sats;
			out_q.hdop <= sto_d.hdop;
			out_q.altitude <= sto_d.alt;
			out_q.fix_age <= sto_d.age;
			out_q.speed_scaled <= sto_d.speed;
			out_q.fix_date <= sto_d.date;
		end
	end

	assign out_valid = out_valid_q;
	assign out_fix = out_q;

endmodule

FILE: design/nmea_sentence_field_parser_core.sv
// NMEA sentence field parser takes one received character per cycle and gives a
// result transaction on each line end or line overflow. A character passes from
// the input register through the combinational line state logic into the result
// register, so the block sustains one character per cycle; the input stalls only
// while a finished result waits in the result register and the input register is
// also full. The line limit register is written through its own channel, which is
// always ready.
module nmea_sentence_field_parser_core
	import nsfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	nsfp_byte_if.sink rx,
	nsfp_fix_if.source fix,
	nsfp_cfg_if.sink cfg
);

	logic [7:0] line_limit_q;
	logic slot_free;
	ev_t ev;
	fix_t out_fix;

	// Line limit register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			line_limit_q <= cfg.line_limit;
		end
	end

	nsfp_line_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rx.valid),
		.in_byte(rx.rx_byte),
		.in_ready(rx.ready),
		.line_limit(line_limit_q),
		.slot_free(slot_free),
		.ev(ev)
	);

	nsfp_fix_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.ev(ev),
		.out_ready(fix.ready),
		.out_valid(fix.valid),
		.out_fix(out_fix),
		.slot_free(slot_free)
	);

	// Result payload onto the channel.
	assign fix.status = out_fix.status;
	assign fix.sentence_kind = out_fix.sentence_kind;
	assign fix.fix_time = out_fix.fix_time;
	assign fix.latitude = out_fix.latitude;
	assign fix.longitude = out_fix.longitude;
	assign fix.satellites = out_fix.satellites;
	assign fix.hdop = out_fix.hdop;
	assign fix.altitude = out_fix.altitude;
	assign fix.fix_age = out_fix.fix_age;
	assign fix.speed_scaled = out_fix.speed_scaled;
	assign fix.fix_date = out_fix.fix_date;

endmodule

FILE: design/nsfp_checker.sv
// Port-level checks of the NMEA sentence field parser result channel.
// Depends on nsfp_pkg; bound to nmea_sentence_field_parser_core.
module nsfp_checker
	import nsfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [2:0] sentence_kind,
	input logic signed [31:0] latitude,
	input logic [41:0] speed_scaled
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(sentence_kind)
			&& $stable(latitude) && $stable(speed_scaled))
		else $error("result payload changed while stalled");

	// Only a good line names a sentence kind.
	a_kind_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_OK) == (sentence_kind != KIND_NONE)))
		else $error("status and sentence kind disagree");

	// Status and kind stay within their codes.
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_UNKNOWN || status == ST_OVERFLOW)
			&& sentence_kind <= KIND_GNS)
		else $error("result code out of range");

endmodule

bind nmea_sentence_field_parser_core nsfp_checker u_nsfp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(fix.valid),
	.out_ready(fix.ready),
	.status(fix.status),
	.sentence_kind(fix.sentence_kind),
	.latitude(fix.latitude),
	.speed_scaled(fix.speed_scaled)
);
